[src/tccu_pkg.sv]
// Shared types and constants of the text console cursor engine.
package tccu_pkg;

   // Mode codes of an input item
   localparam logic [2:0] MODE_PUT  = 3'd0;
   localparam logic [2:0] MODE_BACK = 3'd1;
   localparam logic [2:0] MODE_MOVE = 3'd2;
   localparam logic [2:0] MODE_SET  = 3'd3;
   localparam logic [2:0] MODE_READ = 3'd4;

   // Character and cell codes
   localparam logic [7:0]  NEWLINE_CODE = 8'd10;
   localparam logic [7:0]  SPACE_CODE   = 8'd32;
   localparam logic [15:0] RESET_CELL   = 16'h0720;
   localparam logic [7:0]  COLOR_RESET  = 8'd7;

   // Register map: word index carried in paddr bit 2
   localparam logic REG_TEXT_COLOR = 1'b0;

   // Fixed field widths
   localparam int ROW_W = 5;
   localparam int COL_W = 7;
   localparam int POS_W = 11;
   localparam int LIN_W = 12;

   // Controller to datapath
   typedef struct packed {
      logic accept;     // item transfer this cycle
      logic run;        // sweep counter active
      logic clear;      // sweep writes the reset cell
      logic load_next;  // result from the next cursor
      logic load_cur;   // result from the stored cursor
      logic use_rdata;  // result entry from the store read
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic need_scroll;
      logic is_read;
      logic sweep_done;
   } status_type;

endpackage

[src/tccu_req_if.sv]
// Input channel of the console engine.
interface tccu_req_if;
   logic              valid;
   logic              ready;
   logic [2:0]        mode;
   logic [7:0]        char_code;
   logic signed [7:0] delta_col;
   logic signed [5:0] delta_row;
   logic [7:0]        target_col;
   logic [5:0]        target_row;

   modport source (output valid, mode, char_code, delta_col, delta_row, target_col,
                   target_row, input ready);
   modport sink (input valid, mode, char_code, delta_col, delta_row, target_col,
                 target_row, output ready);
endinterface

[src/tccu_rsp_if.sv]
// Result channel of the console engine.
interface tccu_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] cell_entry;
   logic [4:0]  cursor_row;
   logic [6:0]  cursor_col;
   logic [10:0] cursor_pos;

   modport source (output valid, cell_entry, cursor_row, cursor_col, cursor_pos,
                   input ready);
   modport sink (input valid, cell_entry, cursor_row, cursor_col, cursor_pos,
                 output ready);
endinterface

[src/tccu_ctrl.sv]
// Controller state machine of the console engine.
module tccu_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  tccu_pkg::status_type status,
   output tccu_pkg::cmd_type    cmd
);

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_READ   = 2'd2;
   localparam logic [1:0] ST_SCROLL = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       load;

   // Take a new item only when idle and the result slot is free or draining
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign load      = cmd.load_next || cmd.load_cur;
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.run   = 1'b1;
            cmd.clear = 1'b1;
            if (status.sweep_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               cmd.accept = 1'b1;
               if (status.is_read) state_in = ST_READ;
               else if (status.need_scroll) state_in = ST_SCROLL;
               else cmd.load_next = 1'b1;
            end
         end
         ST_READ: begin
            cmd.load_cur  = 1'b1;
            cmd.use_rdata = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_SCROLL: begin
            cmd.run = 1'b1;
            if (status.sweep_done) begin
               cmd.load_cur = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Result valid: set on load, cleared by the transfer
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A result is never loaded over one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before transfer");

   // A read item waits on the store in the read state, then its result becomes valid
   a_read_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (accept && status.is_read) |=> (state_ff == ST_READ) ##1 rsp_valid_ff)
      else $error("read result not produced after one cycle");

   // A scroll keeps running until the sweep reports done
   a_scroll_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCROLL && !status.sweep_done) |=> (state_ff == ST_SCROLL))
      else $error("scroll left early");

   // No item is taken during the clearing pass
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !cmd.accept && !load)
      else $error("activity during clearing pass");

endmodule

[src/tccu_datapath.sv]
// Datapath of the console engine: cursor, cell store, sweep counter, result.
module tccu_datapath #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tccu_pkg::cmd_type    cmd,
   output tccu_pkg::status_type status,
   input  logic                 color_we,
   input  logic [7:0]           color_wdata,
   output logic [7:0]           color,
   input  logic [2:0]           mode,
   input  logic [7:0]           char_code,
   input  logic signed [7:0]    delta_col,
   input  logic signed [5:0]    delta_row,
   input  logic [7:0]           target_col,
   input  logic [5:0]           target_row,
   output logic [15:0]          cell_entry,
   output logic [4:0]           cursor_row,
   output logic [6:0]           cursor_col,
   output logic [10:0]          cursor_pos
);

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int AW     = $clog2(CELLS);
   localparam int KW     = $clog2(CELLS + 1);
   localparam int LW     = tccu_pkg::LIN_W;
   localparam int RW     = tccu_pkg::ROW_W;
   localparam int CW     = tccu_pkg::COL_W;
   localparam int PW     = tccu_pkg::POS_W;
   localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);
   localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
   localparam logic [KW-1:0] COPY_N   = KW'(CELLS - COLUMNS);
   localparam logic [KW-1:0] SWEEP_N  = KW'(CELLS);

   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [7:0]    color_ff, color_in;
   logic [KW-1:0] k_ff, k_in;
   logic [15:0]   cell_store_ff [CELLS];
   logic [15:0]   rdata_ff;
   logic [15:0]   entry_ff, entry_in;
   logic [RW-1:0] out_row_ff, out_row_in;
   logic [CW-1:0] out_col_ff, out_col_in;
   logic [PW-1:0] out_pos_ff, out_pos_in;

   logic [RW-1:0]     nrow;
   logic [CW-1:0]     ncol;
   logic              need_scroll;
   logic              item_we;
   logic [LW-1:0]     item_lin;
   logic [15:0]       item_wdata;
   logic [LW-1:0]     cur_lin, next_lin, read_lin;
   logic [CW-1:0]     tcol_c;
   logic [RW-1:0]     trow_c;
   logic signed [8:0] col_sum;
   logic signed [6:0] row_sum;
   logic [15:0]       blank;
   logic [KW-1:0]     k_prev, k_src;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr, mem_raddr;
   logic [15:0]       mem_wdata;

   assign blank   = {color_ff, tccu_pkg::SPACE_CODE};
   assign cur_lin = LW'(row_ff) * LW'(COLUMNS) + LW'(col_ff);

   // Clamped targets for absolute set and read
   assign tcol_c   = (target_col >= 8'(COLUMNS)) ? LAST_COL : target_col[CW-1:0];
   assign trow_c   = (target_row >= 6'(ROWS)) ? LAST_ROW : target_row[RW-1:0];
   assign read_lin = LW'(trow_c) * LW'(COLUMNS) + LW'(tcol_c);

   assign col_sum = $signed({2'b00, col_ff}) + $signed({delta_col[7], delta_col});
   assign row_sum = $signed({2'b00, row_ff}) + $signed({delta_row[5], delta_row});

   // Next cursor and the cell write of the item
   always_comb begin
      nrow        = row_ff;
      ncol        = col_ff;
      need_scroll = 1'b0;
      item_we     = 1'b0;
      item_lin    = cur_lin;
      item_wdata  = blank;
      unique case (mode)
         tccu_pkg::MODE_PUT: begin
            if (char_code != tccu_pkg::NEWLINE_CODE) begin
               item_we    = 1'b1;
               item_wdata = {color_ff, char_code};
            end
            if (char_code == tccu_pkg::NEWLINE_CODE || col_ff == LAST_COL) begin
               ncol = '0;
               if (row_ff == LAST_ROW) need_scroll = 1'b1;
               else nrow = row_ff + RW'(1);
            end else begin
               ncol = col_ff + CW'(1);
            end
         end
         tccu_pkg::MODE_BACK: begin
            // previous cell is always one linear step back
            item_lin = cur_lin - LW'(1);
            if (col_ff != '0) begin
               ncol    = col_ff - CW'(1);
               item_we = 1'b1;
            end else if (row_ff != '0) begin
               nrow    = row_ff - RW'(1);
               ncol    = LAST_COL;
               item_we = 1'b1;
            end
         end
         tccu_pkg::MODE_MOVE: begin
            if (col_sum < 0) ncol = '0;
            else if (col_sum > $signed({2'b00, LAST_COL})) ncol = LAST_COL;
            else ncol = col_sum[CW-1:0];
            if (row_sum < 0) nrow = '0;
            else if (row_sum > $signed({2'b00, LAST_ROW})) nrow = LAST_ROW;
            else nrow = row_sum[RW-1:0];
         end
         tccu_pkg::MODE_SET: begin
            ncol = tcol_c;
            nrow = trow_c;
         end
         default: ;
      endcase
   end

   assign next_lin = LW'(nrow) * LW'(COLUMNS) + LW'(ncol);

   assign status.need_scroll = need_scroll;
   assign status.is_read     = (mode == tccu_pkg::MODE_READ);
   assign status.sweep_done  = (k_ff == SWEEP_N);

   // Sweep: read one row ahead, write at the previous count in the cycle after
   assign k_prev = k_ff - KW'(1);
   assign k_src  = (k_ff < COPY_N) ? k_ff + KW'(COLUMNS) : '0;

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = item_lin[AW-1:0];
      mem_wdata = item_wdata;
      mem_raddr = read_lin[AW-1:0];
      if (cmd.run) begin
         mem_raddr = k_src[AW-1:0];
         mem_waddr = k_prev[AW-1:0];
         mem_we    = (k_ff != '0);
         if (cmd.clear) mem_wdata = tccu_pkg::RESET_CELL;
         else if (k_prev < COPY_N) mem_wdata = rdata_ff;
         else mem_wdata = blank;
      end else if (cmd.accept) begin
         mem_we = item_we;
      end
   end

   // Cell store: one write port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) cell_store_ff[mem_waddr] <= mem_wdata;
      rdata_ff <= cell_store_ff[mem_raddr];
   end

   // Control registers
   assign row_in   = cmd.accept ? nrow : row_ff;
   assign col_in   = cmd.accept ? ncol : col_ff;
   assign color_in = color_we ? color_wdata : color_ff;
   always_comb begin
      k_in = k_ff;
      if (cmd.accept) k_in = '0;
      else if (cmd.run && !status.sweep_done) k_in = k_ff + KW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= '0;
         col_ff   <= '0;
         color_ff <= tccu_pkg::COLOR_RESET;
         k_ff     <= '0;
      end else begin
         row_ff   <= row_in;
         col_ff   <= col_in;
         color_ff <= color_in;
         k_ff     <= k_in;
      end
   end

   // Result register
   always_comb begin
      entry_in   = entry_ff;
      out_row_in = out_row_ff;
      out_col_in = out_col_ff;
      out_pos_in = out_pos_ff;
      if (cmd.load_next) begin
         entry_in   = '0;
         out_row_in = nrow;
         out_col_in = ncol;
         out_pos_in = next_lin[PW-1:0];
      end else if (cmd.load_cur) begin
         entry_in   = cmd.use_rdata ? rdata_ff : '0;
         out_row_in = row_ff;
         out_col_in = col_ff;
         out_pos_in = cur_lin[PW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      entry_ff   <= entry_in;
      out_row_ff <= out_row_in;
      out_col_ff <= out_col_in;
      out_pos_ff <= out_pos_in;
   end

   assign color      = color_ff;
   assign cell_entry = entry_ff;
   assign cursor_row = out_row_ff;
   assign cursor_col = out_col_ff;
   assign cursor_pos = out_pos_ff;

endmodule

[src/text_console_cursor_engine_unit.sv]
// Top level of the text console cursor engine.
//
// Text-mode console: a COLUMNS x ROWS store of 16-bit cells (attribute high byte,
// glyph low byte) and a cursor, driven one item per transfer with one result per
// item. Put character, backspace, relative move and absolute set items stream at
// one per cycle while the result side keeps up and no scroll is needed. A cell
// read waits in a read state for the registered read port of the store. An item
// that runs past the bottom row scrolls the store by a copy pass that moves every
// cell up one row and blanks the last row in the current color. After reset the
// store is cleared to grey spaces by a pass during which no item is taken; the
// text_color register at byte address 0 can be written at any time.
module text_console_cursor_engine_unit #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic        clock,
   input  logic        reset,
   tccu_req_if.sink    req_ch,
   tccu_rsp_if.source  rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   tccu_pkg::cmd_type    cmd;
   tccu_pkg::status_type status;
   logic                 color_we;
   logic [7:0]           color;

   // Register port: single register, zero-wait
   assign csr_pready = 1'b1;
   assign color_we   = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[2] == tccu_pkg::REG_TEXT_COLOR);
   assign csr_prdata = (csr_paddr[2] == tccu_pkg::REG_TEXT_COLOR) ? {24'd0, color} : 32'd0;

   tccu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tccu_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .color_we    (color_we),
      .color_wdata (csr_pwdata[7:0]),
      .color       (color),
      .mode        (req_ch.mode),
      .char_code   (req_ch.char_code),
      .delta_col   (req_ch.delta_col),
      .delta_row   (req_ch.delta_row),
      .target_col  (req_ch.target_col),
      .target_row  (req_ch.target_row),
      .cell_entry  (rsp_ch.cell_entry),
      .cursor_row  (rsp_ch.cursor_row),
      .cursor_col  (rsp_ch.cursor_col),
      .cursor_pos  (rsp_ch.cursor_pos)
   );

endmodule
